// File: hdl/cfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_pkg: clock tree frequency calculator package
// Shared types, constants and helper functions for the calculator blocks.
// ----------------------------------------------------------------------------
package cfc_pkg;

    // Field widths
    localparam int SRC_W    = 26;               // oscillator frequency width
    localparam int M_W      = 6;
    localparam int N_W      = 9;
    localparam int CORE_W   = SRC_W + N_W;       // full-precision core frequency
    localparam int HZ_W     = 32;
    localparam int WS_W     = 3;
    localparam int AHB_SH_W = 4;
    localparam int APB_SH_W = 3;

    // Divider organization
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = SRC_W / DIV_BITS_PER_STAGE;
    localparam int BIT_IDX_W          = $clog2(SRC_W);

    // Queue between front and back
    localparam int CFC_QUEUE_DEPTH = 4;

    // Flash latency thresholds
    localparam int unsigned FLASH_STEP_HZ = 30000000;
    localparam int          FLASH_WS_MAX  = 7;

    localparam logic [SRC_W-1:0] HSE_RESET_HZ = SRC_W'(0);
    localparam logic [SRC_W-1:0] HSI_RESET_HZ = SRC_W'(16000000);

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_HSE_HZ = 1'b0,
        REG_HSI_HZ = 1'b1
    } cfg_idx_t;

    // Clock switch status codes
    typedef enum logic [1:0] {
        STS_HSI     = 2'd0,
        STS_HSE     = 2'd1,
        STS_PLL     = 2'd2,
        STS_HSI_ALT = 2'd3
    } src_sts_t;

    typedef struct packed {
        logic [1:0]     source_status;
        logic           pll_from_hse;
        logic [M_W-1:0] pll_m;
        logic [N_W-1:0] pll_n;
        logic [1:0]     pll_p_code;
        logic [3:0]     ahb_prescale;
        logic [2:0]     apb1_prescale;
        logic [2:0]     apb2_prescale;
    } cfc_in_t;

    typedef struct packed {
        logic [HZ_W-1:0] core_hz;
        logic [HZ_W-1:0] ahb_hz;
        logic [HZ_W-1:0] apb1_hz;
        logic [HZ_W-1:0] apb2_hz;
        logic [WS_W-1:0] flash_wait_states;
        logic            prefetch_on;
        logic            pll_error;
    } cfc_out_t;

    // Classified job handed from front to back
    typedef struct packed {
        logic                use_pll;
        logic                err;
        logic [SRC_W-1:0]    src;
        logic [M_W-1:0]      m;
        logic [N_W-1:0]      n;
        logic [1:0]          p_code;
        logic [AHB_SH_W-1:0] ahb_shift;
        logic [APB_SH_W-1:0] apb1_shift;
        logic [APB_SH_W-1:0] apb2_shift;
    } cfc_job_t;

    // Divider pipeline slot
    typedef struct packed {
        cfc_job_t         job;
        logic [SRC_W-1:0] quo;
        logic [M_W-1:0]   rem;
    } cfc_div_t;

    // Queue status toward front and top
    typedef struct packed {
        logic empty;
        logic full;
        logic almost_full;
    } cfc_q_status_t;

    // One restoring divide step on one dividend bit
    function automatic cfc_div_t div_step(input cfc_div_t d,
                                          input logic [BIT_IDX_W-1:0] bit_idx);
        cfc_div_t       r;
        logic [M_W:0]   trial;
        logic [M_W:0]   dvs;
        r     = d;
        trial = {d.rem, d.job.src[bit_idx]};
        dvs   = {1'b0, d.job.m};
        if (trial >= dvs)
        begin
            r.rem = M_W'(trial - dvs);
            r.quo = {d.quo[SRC_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[M_W-1:0];
            r.quo = {d.quo[SRC_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [HZ_W-1:0] sat32(input logic [CORE_W-1:0] v);
        return (|v[CORE_W-1:HZ_W]) ? {HZ_W{1'b1}} : v[HZ_W-1:0];
    endfunction

    // Wait states: number of 30 MHz steps exceeded, capped at the maximum
    function automatic logic [WS_W-1:0] flash_ws(input logic [CORE_W-1:0] bus);
        logic [WS_W-1:0] ws;
        ws = '0;
        for (int k = 1; k <= FLASH_WS_MAX; k++)
        begin
            if (bus > CORE_W'(longint'(k) * longint'(FLASH_STEP_HZ)))
                ws = WS_W'(k);
        end
        return ws;
    endfunction

endpackage
`default_nettype wire

// File: hdl/cfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_front: command front end
// Accept a transaction, pick the oscillator, decode prescalers, flag bad M.
// ----------------------------------------------------------------------------
module cfc_front
    import cfc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire cfc_in_t           item,
    input  wire logic [SRC_W-1:0]  hse_hz,
    input  wire logic [SRC_W-1:0]  hsi_hz,
    output logic                   push,
    output cfc_job_t               job
);

    logic     vld_reg;
    logic     vld_next;
    cfc_job_t job_reg;
    cfc_job_t job_next;

    always_comb
    begin
        vld_next            = start && !busy;
        job_next.use_pll    = 1'b0;
        job_next.src        = hsi_hz;
        unique case (src_sts_t'(item.source_status))
            STS_HSE:
            begin
                job_next.src = hse_hz;
            end
            STS_PLL:
            begin
                job_next.use_pll = 1'b1;
                job_next.src     = item.pll_from_hse ? hse_hz : hsi_hz;
            end
            STS_HSI, STS_HSI_ALT:
            begin
                job_next.src = hsi_hz;
            end
            default:
            begin
                job_next.src = hsi_hz;
            end
        endcase
        job_next.err    = job_next.use_pll && (item.pll_m < M_W'(2));
        job_next.m      = item.pll_m;
        job_next.n      = item.pll_n;
        job_next.p_code = item.pll_p_code;
        // AHB codes 12..15 skip divide by 32
        if (item.ahb_prescale[3])
            job_next.ahb_shift = (item.ahb_prescale[2:0] > 3'd3)
                ? AHB_SH_W'(item.ahb_prescale[2:0]) + AHB_SH_W'(2)
                : AHB_SH_W'(item.ahb_prescale[2:0]) + AHB_SH_W'(1);
        else
            job_next.ahb_shift = '0;
        job_next.apb1_shift = item.apb1_prescale[2]
            ? APB_SH_W'(item.apb1_prescale[1:0]) + APB_SH_W'(1) : '0;
        job_next.apb2_shift = item.apb2_prescale[2]
            ? APB_SH_W'(item.apb2_prescale[1:0]) + APB_SH_W'(1) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (vld_next)
            job_reg <= job_next;
    end

    assign push = vld_reg;
    assign job  = job_reg;

endmodule
`default_nettype wire

// File: hdl/cfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_queue: job queue
// Short FIFO that decouples the command front end from the compute back end.
// ----------------------------------------------------------------------------
module cfc_queue
    import cfc_pkg::*;
#(
    parameter int DEPTH = CFC_QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire cfc_job_t push_data,
    input  wire logic     pop,
    output cfc_job_t      pop_data,
    output cfc_q_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfc_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data           = mem_reg[rd_ptr_reg];
    assign status.empty       = (count_reg == '0);
    assign status.full        = (count_reg == CNT_W'(DEPTH));
    assign status.almost_full = (count_reg >= CNT_W'(DEPTH - 1));

endmodule
`default_nettype wire

// File: hdl/cfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_back: compute back end
// Pipelined M divider, N multiplier, P/AHB/APB shifts and flash latency.
// ----------------------------------------------------------------------------
module cfc_back
    import cfc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     job_vld,
    input  wire cfc_job_t job,
    output logic          result_valid,
    output cfc_out_t      result
);

    localparam int LAST = DIV_STAGES - 1;

    // Divider pipeline
    logic [DIV_STAGES-1:0] stg_vld_reg;
    cfc_div_t              stg_reg  [DIV_STAGES];
    cfc_div_t              stg_in   [DIV_STAGES];
    cfc_div_t              stg_next [DIV_STAGES];

    assign stg_in[0].job = job;
    assign stg_in[0].quo = '0;
    assign stg_in[0].rem = '0;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        cfc_div_t chain [DIV_BITS_PER_STAGE+1];
        if (s > 0)
        begin : g_link
            assign stg_in[s] = stg_reg[s-1];
        end
        assign chain[0] = stg_in[s];
        for (genvar j = 0; j < DIV_BITS_PER_STAGE; j++)
        begin : g_bit
            localparam int IDX = SRC_W - 1 - (s * DIV_BITS_PER_STAGE + j);
            assign chain[j+1] = div_step(chain[j], BIT_IDX_W'(IDX));
        end
        assign stg_next[s] = chain[DIV_BITS_PER_STAGE];

        always_ff @(posedge clk)
        begin
            stg_reg[s] <= stg_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_vld_reg <= '0;
        else
            stg_vld_reg <= {stg_vld_reg[DIV_STAGES-2:0], job_vld};
    end

    // Multiply stage
    logic              mul_vld_reg;
    cfc_job_t          mul_job_reg;
    logic [CORE_W-1:0] mul_prod_reg;

    // Core and AHB stage
    logic              bus_vld_reg;
    logic [CORE_W-1:0] core_reg;
    logic [CORE_W-1:0] bus_reg;
    logic              err_reg;
    logic [APB_SH_W-1:0] apb1_sh_reg;
    logic [APB_SH_W-1:0] apb2_sh_reg;
    logic [CORE_W-1:0] core_next;

    // Output stage
    logic     out_vld_reg;
    cfc_out_t out_reg;
    cfc_out_t out_next;

    always_comb
    begin
        if (mul_job_reg.err)
            core_next = '0;
        else if (mul_job_reg.use_pll)
            core_next = mul_prod_reg >> ({1'b0, mul_job_reg.p_code} + 3'd1);
        else
            core_next = CORE_W'(mul_job_reg.src);
    end

    always_comb
    begin
        out_next.core_hz           = sat32(core_reg);
        out_next.ahb_hz            = sat32(bus_reg);
        out_next.apb1_hz           = sat32(bus_reg >> apb1_sh_reg);
        out_next.apb2_hz           = sat32(bus_reg >> apb2_sh_reg);
        out_next.flash_wait_states = flash_ws(bus_reg);
        out_next.prefetch_on       = (bus_reg > CORE_W'(FLASH_STEP_HZ));
        out_next.pll_error         = err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            bus_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= stg_vld_reg[LAST];
            bus_vld_reg <= mul_vld_reg;
            out_vld_reg <= bus_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_job_reg  <= stg_reg[LAST].job;
        mul_prod_reg <= CORE_W'(stg_reg[LAST].quo) * CORE_W'(stg_reg[LAST].job.n);
        core_reg     <= core_next;
        bus_reg      <= core_next >> mul_job_reg.ahb_shift;
        err_reg      <= mul_job_reg.err;
        apb1_sh_reg  <= mul_job_reg.apb1_shift;
        apb2_sh_reg  <= mul_job_reg.apb2_shift;
        out_reg      <= out_next;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// File: hdl/clock_tree_frequency_calc_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_tree_frequency_calc_unit: clock tree frequency calculator
// Derives core, AHB, APB1 and APB2 frequencies and flash latency from clock
// configuration codes.
// ----------------------------------------------------------------------------
// A transaction is accepted at every clock edge with start high and busy low;
// one transaction per cycle is sustained indefinitely. Each result appears on
// result for exactly one cycle with result_valid high, in order. A command
// passes the command register and the job queue, then the divider for the
// PLL input divider M, which resolves two quotient bits per stage over 13
// stages, followed by one multiply stage, one core/AHB shift stage and one
// output stage.
// The receiver cannot stall, so the back end drains the queue every cycle and
// busy stays low in normal use. hse_hz and hsi_hz are written through cfg_we,
// cfg_index and cfg_data and must only be changed while the unit is idle.
// ----------------------------------------------------------------------------
module clock_tree_frequency_calc_unit
    import cfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = CFC_QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cfc_in_t          item,
    input  wire logic             cfg_we,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [SRC_W-1:0] cfg_data,
    output logic                  result_valid,
    output cfc_out_t              result
);

    // Oscillator frequency registers
    logic [SRC_W-1:0] hse_hz_reg;
    logic [SRC_W-1:0] hsi_hz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hse_hz_reg <= HSE_RESET_HZ;
            hsi_hz_reg <= HSI_RESET_HZ;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_HSE_HZ: hse_hz_reg <= cfg_data;
                REG_HSI_HZ: hsi_hz_reg <= cfg_data;
                default:    hse_hz_reg <= hse_hz_reg;
            endcase
        end
    end

    // Front end: register the command and classify it
    logic          q_push;
    cfc_job_t      q_push_data;
    cfc_job_t      q_pop_data;
    logic          q_pop;
    cfc_q_status_t q_status;

    cfc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .hse_hz (hse_hz_reg),
        .hsi_hz (hsi_hz_reg),
        .push   (q_push),
        .job    (q_push_data)
    );

    // Hold off new commands once the queue could not absorb the one in flight
    assign busy = q_status.almost_full;

    cfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    // Back end never stalls: drain one job per cycle
    assign q_pop = !q_status.empty;

    cfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_vld      (q_pop),
        .job          (q_pop_data),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    // Queue never takes a job while full
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (!q_status.full || q_pop))
        else $error("job queue overflow");

    // Bad PLL divider zeroes every frequency of that result
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.pll_error) |->
            (result.core_hz == '0 && result.ahb_hz == '0 && result.prefetch_on == 1'b0))
        else $error("pll error result carries a nonzero frequency");

    // Wait states only appear with prefetch on
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.prefetch_on) |-> (result.flash_wait_states == '0))
        else $error("wait states set below the first flash step");

    // An accepted command reaches the queue on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> q_push)
        else $error("accepted command not queued");
`endif

endmodule
`default_nettype wire

// File: tb/tb_clock_tree_frequency_calc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_tree_frequency_calc_unit: clock tree frequency calculator bench
// Drives clock configuration commands into the unit, predicts core, bus and
// flash settings for each accepted command and checks every result in order.
// ----------------------------------------------------------------------------
module tb_clock_tree_frequency_calc_unit;
    import cfc_pkg::*;

    // Wait-state ceiling: above seven 30 MHz steps the latency pins at maximum
    localparam longint unsigned WS_CAP_HZ  = longint'(FLASH_STEP_HZ) * FLASH_WS_MAX;
    localparam longint unsigned HZ_MAX     = 64'hFFFF_FFFF;
    localparam int              IDLE_LIMIT = 1000;
    localparam int              PHASE_LEN  = 220;
    localparam int              NUM_PHASES = 7;

    // ------------------------------------------------------------------------
    // Frequency scoreboard: mirror of the two oscillator registers, prediction
    // of each result and the queue of results still to come.
    // ------------------------------------------------------------------------
    class freq_scoreboard;
        logic [SRC_W-1:0] hse_hz;
        logic [SRC_W-1:0] hsi_hz;
        cfc_out_t         expected_freqs[$];
        int               mismatches;
        int               checked;

        function new();
            hse_hz     = HSE_RESET_HZ;
            hsi_hz     = HSI_RESET_HZ;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void note_config(cfg_idx_t idx, logic [SRC_W-1:0] value);
            if (idx == REG_HSE_HZ)
                hse_hz = value;
            else
                hsi_hz = value;
        endfunction

        function logic [HZ_W-1:0] clamp_hz(longint unsigned v);
            return (v > HZ_MAX) ? {HZ_W{1'b1}} : v[HZ_W-1:0];
        endfunction

        // Full-precision clock tree evaluation; saturation only at the outputs
        function cfc_out_t predict_freqs(cfc_in_t cmd);
            cfc_out_t        r;
            longint unsigned core;
            longint unsigned bus;
            longint unsigned p1;
            longint unsigned p2;
            longint unsigned osc;
            int unsigned     sh;
            r = '0;
            case (src_sts_t'(cmd.source_status))
                STS_HSE: core = 64'(hse_hz);
                STS_PLL:
                begin
                    if (cmd.pll_m < 2)
                    begin
                        r.pll_error = 1'b1;
                        core        = 0;
                    end
                    else
                    begin
                        osc  = 64'(cmd.pll_from_hse ? hse_hz : hsi_hz);
                        core = (osc / cmd.pll_m) * cmd.pll_n / (64'd2 << cmd.pll_p_code);
                    end
                end
                default: core = 64'(hsi_hz);   // internal, and the alternate code
            endcase

            bus = core;
            if (cmd.ahb_prescale[3])
            begin
                sh = 32'(cmd.ahb_prescale[2:0]);
                if (sh > 3)
                    sh++;   // codes past divide-by-16 skip divide-by-32
                bus = core >> (sh + 1);
            end
            p1 = cmd.apb1_prescale[2] ? (bus >> (cmd.apb1_prescale[1:0] + 1)) : bus;
            p2 = cmd.apb2_prescale[2] ? (bus >> (cmd.apb2_prescale[1:0] + 1)) : bus;

            if (bus > FLASH_STEP_HZ)
            begin
                r.prefetch_on = 1'b1;
                if (bus > WS_CAP_HZ)
                    r.flash_wait_states = WS_W'(FLASH_WS_MAX);
                else
                    r.flash_wait_states = WS_W'((bus - 1) / FLASH_STEP_HZ);
            end
            r.core_hz = clamp_hz(core);
            r.ahb_hz  = clamp_hz(bus);
            r.apb1_hz = clamp_hz(p1);
            r.apb2_hz = clamp_hz(p2);
            return r;
        endfunction

        function void note_input(cfc_in_t cmd);
            expected_freqs.push_back(predict_freqs(cmd));
        endfunction

        function int pending();
            return expected_freqs.size();
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            mismatches++;
            $display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
                     $realtime, checked, what, got, want);
        endtask

        task check_result(cfc_out_t got);
            cfc_out_t want;
            if (expected_freqs.size() == 0)
            begin
                report_mismatch("result with no transaction waiting", 1, 0);
                return;
            end
            want = expected_freqs.pop_front();
            if (got.core_hz !== want.core_hz)
                report_mismatch("core_hz", got.core_hz, want.core_hz);
            if (got.ahb_hz !== want.ahb_hz)
                report_mismatch("ahb_hz", got.ahb_hz, want.ahb_hz);
            if (got.apb1_hz !== want.apb1_hz)
                report_mismatch("apb1_hz", got.apb1_hz, want.apb1_hz);
            if (got.apb2_hz !== want.apb2_hz)
                report_mismatch("apb2_hz", got.apb2_hz, want.apb2_hz);
            if (got.flash_wait_states !== want.flash_wait_states)
                report_mismatch("flash_wait_states", got.flash_wait_states,
                                want.flash_wait_states);
            if (got.prefetch_on !== want.prefetch_on)
                report_mismatch("prefetch_on", got.prefetch_on, want.prefetch_on);
            if (got.pll_error !== want.pll_error)
                report_mismatch("pll_error", got.pll_error, want.pll_error);
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the unit under test
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cfc_in_t          item;
    logic             cfg_we;
    logic [0:0]       cfg_index;
    logic [SRC_W-1:0] cfg_data;
    logic             result_valid;
    cfc_out_t         result;

    freq_scoreboard   sb;
    int               idle_cycles;
    int               no_idle_left;

    clock_tree_frequency_calc_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitors: everything is sampled at the rising edge, before the
    // nonblocking updates of that edge land.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            sb.note_config(cfg_idx_t'(cfg_index), cfg_data);
        if (rst_n && start && !busy)
            sb.note_input(item);
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    // Watchdog: abort when neither side moves a transaction for too long
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || (rst_n && result_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly back-to-back or short gaps, a few long ones, and now and then a
    // stretch with no idling at all.
    function automatic int next_gap();
        int r;
        if (no_idle_left > 0)
        begin
            no_idle_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            no_idle_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic cfc_in_t make_cmd(src_sts_t sts, logic from_hse,
                                         int m, int n, int p,
                                         int ahb, int apb1, int apb2);
        cfc_in_t c;
        c.source_status = sts;
        c.pll_from_hse  = from_hse;
        c.pll_m         = M_W'(m);
        c.pll_n         = N_W'(n);
        c.pll_p_code    = 2'(p);
        c.ahb_prescale  = 4'(ahb);
        c.apb1_prescale = 3'(apb1);
        c.apb2_prescale = 3'(apb2);
        return c;
    endfunction

    // Lean toward the PLL path, with a share of illegal M values
    function automatic cfc_in_t random_cmd();
        cfc_in_t     c;
        logic [31:0] rnd;
        rnd = $urandom;
        c   = rnd[$bits(cfc_in_t)-1:0];
        if ($urandom_range(0, 99) < 55)
            c.source_status = STS_PLL;
        else
            c.source_status = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
            c.pll_m = M_W'($urandom_range(0, 1));
        else
            c.pll_m = M_W'($urandom_range(2, 63));
        return c;
    endfunction

    // Hold off until every predicted result has been checked
    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Present one command, hold it until accepted, then idle or drain
    task automatic drive_item(input cfc_in_t cmd, input bit drain);
        int gap;
        start <= 1'b1;
        item  <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = next_gap();
        if (gap > 0 || drain)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            if (drain)
                wait_drained();
        end
    endtask

    // Write both oscillator registers on consecutive edges; unit must be idle
    task automatic write_osc_regs(input logic [SRC_W-1:0] hse_v,
                                  input logic [SRC_W-1:0] hsi_v);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HSE_HZ;
        cfg_data  <= hse_v;
        @(posedge clk);
        cfg_index <= REG_HSI_HZ;
        cfg_data  <= hsi_v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [SRC_W-1:0] hse_set [NUM_PHASES];
        logic [SRC_W-1:0] hsi_set [NUM_PHASES];

        sb           = new();
        no_idle_left = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_HSE_HZ;
        cfg_data  <= '0;

        // Extremes, threshold neighbors and a couple of random settings
        hse_set = '{26'd50000000, 26'd0, 26'd30000001, 26'h3FFFFFF,
                    26'($urandom_range(0, 50000000)), 26'd25000000,
                    26'($urandom_range(0, 50000000))};
        hsi_set = '{26'd16000000, 26'd50000000, 26'd30000000, 26'h3FFFFFF,
                    26'($urandom_range(0, 50000000)), 26'd0,
                    26'($urandom_range(0, 50000000))};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Run a few commands on the reset values of the oscillator registers
        for (int i = 0; i < 20; i++)
            drive_item(random_cmd(), i == 19);

        write_osc_regs(26'd50000000, 26'd16000000);

        // Directed: source selection, both error codes and their neighbors
        drive_item(make_cmd(STS_HSI,     0,  0,   0, 0,  0, 0, 0), 0);
        drive_item(make_cmd(STS_HSE,     0,  0,   0, 0,  0, 0, 0), 0);
        drive_item(make_cmd(STS_HSI_ALT, 1,  1, 511, 3,  0, 0, 0), 0);
        drive_item(make_cmd(STS_PLL,     1,  0, 300, 0,  0, 0, 0), 0);
        drive_item(make_cmd(STS_PLL,     0,  1, 300, 1,  0, 0, 0), 0);
        drive_item(make_cmd(STS_HSI,     0,  0, 511, 3, 15, 7, 7), 0);
        drive_item(make_cmd(STS_HSE,     1,  1, 511, 3,  0, 0, 0), 0);
        // PLL from 16 MHz / 16 / 2: n/2 MHz, straddling the flash thresholds
        drive_item(make_cmd(STS_PLL,     0, 16,  60, 0,  0, 0, 0), 0);
        drive_item(make_cmd(STS_PLL,     0, 16,  62, 0,  0, 0, 0), 0);
        drive_item(make_cmd(STS_PLL,     0, 16, 121, 0,  0, 0, 0), 0);
        drive_item(make_cmd(STS_PLL,     0, 16, 420, 0,  0, 0, 0), 0);
        drive_item(make_cmd(STS_PLL,     0, 16, 422, 0,  0, 0, 0), 0);
        // Wide values: saturated core with unsaturated bus, and the reverse mix
        drive_item(make_cmd(STS_PLL,     1,  2, 511, 0,  8, 4, 0), 0);
        drive_item(make_cmd(STS_PLL,     1,  2, 511, 0,  0, 7, 0), 0);
        drive_item(make_cmd(STS_PLL,     1, 63,   0, 2,  0, 0, 0), 0);
        drive_item(make_cmd(STS_PLL,     1,  2, 511, 3,  0, 0, 0), 0);
        drive_item(make_cmd(STS_PLL,     1, 63, 511, 3, 15, 7, 7), 0);
        // Every divided AHB code, with the APB codes walked both ways
        for (int k = 0; k < 8; k++)
            drive_item(make_cmd(STS_HSE, 0, 2, 0, 0, 8 + k, 4 + (k % 4), 7 - (k % 4)),
                       k == 7);

        // Random phases, one register setting each; drain once mid-phase
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_osc_regs(hse_set[ph], hsi_set[ph]);
            for (int i = 0; i < PHASE_LEN; i++)
                drive_item(random_cmd(), (i == PHASE_LEN / 2) || (i == PHASE_LEN - 1));
        end

        // Let any stray result show up before the verdict
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
